>>> sv/ntpcal_pkg.sv
`default_nettype none

package ntpcal_pkg;

  // field widths
  localparam int unsigned NtpW    = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned TzW     = 5;
  localparam int unsigned OutW    = 40;

  localparam logic [NtpW-1:0] NtpUnixOffset = 32'd2208988800;
  localparam logic [16:0]     SecsPerDay    = 17'd86400;
  localparam logic [16:0]     SecsPerHour   = 17'd3600;
  localparam logic [16:0]     SecsPerMin    = 17'd60;
  localparam logic [YearW-1:0] EpochYear    = 12'd1970;
  // 1970 taken modulo 4, 100 and 400
  localparam logic [1:0]      EpochMod4     = 2'd2;
  localparam logic [6:0]      EpochMod100   = 7'd70;
  localparam logic [8:0]      EpochMod400   = 9'd370;
  localparam logic [MonthW-1:0] LastMonth   = 4'd11;
  localparam logic [TzW-1:0]  TzReset       = 5'd8;

  // reciprocals rounded up: ceil(2^35 / 675), ceil(2^21 / 225), ceil(2^14 / 15)
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam logic DayLastStep    = 1'b1;
  localparam logic HourLastStep   = 1'b1;
  localparam logic MinuteLastStep = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } ntpcal_state_e;

  typedef struct packed {
    logic       load;
    logic       adjust;
    logic       day_step;
    logic       hour_step;
    logic       min_step;
    logic       year_step;
    logic       month_step;
    logic       out_load;
    logic       step_idx;
  } ntpcal_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } ntpcal_status_t;

  // month index from 0
  function automatic logic [4:0] month_len(input logic [MonthW-1:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> sv/ntpcal_dpath.sv
`default_nettype none

module ntpcal_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ntpcal_pkg::TzW-1:0]   cfg_wdata_i,
  input  wire logic [ntpcal_pkg::NtpW-1:0]  ntp_seconds_i,
  input  wire ntpcal_pkg::ntpcal_cmd_t      cmd_i,
  output ntpcal_pkg::ntpcal_status_t        status_o,
  output logic [ntpcal_pkg::OutW-1:0]       result_o
);
  import ntpcal_pkg::*;

  logic signed [TzW-1:0] tz_q, tz_d;
  logic [NtpW-1:0]    t_q, t_d;
  logic [16:0]        rem_q, rem_d;
  logic [15:0]        days_q, days_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [MinuteW-1:0] min_q, min_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [1:0]         y4_q, y4_d;
  logic [6:0]         y100_q, y100_d;
  logic [8:0]         y400_q, y400_d;
  logic [MonthW-1:0]  month_q, month_d;

  logic [YearW-1:0]   out_year_q, out_year_d;
  logic [MonthW-1:0]  out_month_q, out_month_d;
  logic [DayW-1:0]    out_day_q, out_day_d;
  logic [HourW-1:0]   out_hour_q, out_hour_d;
  logic [MinuteW-1:0] out_min_q, out_min_d;
  logic [SecondW-1:0] out_sec_q, out_sec_d;

  logic signed [16:0] tz_secs;
  logic [NtpW-1:0]    t_adj;
  logic [50:0]        day_prod;
  logic [16:0]        day_mul;
  logic [25:0]        hour_prod;
  logic [16:0]        hour_mul;
  logic [19:0]        min_prod;
  logic [16:0]        min_mul;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;

  assign tz_secs  = 17'(tz_q) * 17'sd3600;
  assign t_adj    = t_q + 32'(tz_secs);

  // quotients by reciprocal multiplication: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
  assign day_prod  = 51'(t_q[31:7]) * 51'(DayRecip);
  assign day_mul   = 17'(days_q) * SecsPerDay;
  assign hour_prod = 26'(rem_q[16:4]) * 26'(HourRecip);
  assign hour_mul  = 17'(hour_q) * SecsPerHour;
  assign min_prod  = 20'(rem_q[11:2]) * 20'(MinRecip);
  assign min_mul   = 17'(min_q) * SecsPerMin;

  assign leap = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_q, leap);

  assign status_o.year_done  = days_q < 16'(ylen);
  assign status_o.month_done = (month_q == LastMonth) || (days_q < 16'(mlen));

  always_comb begin
    tz_d        = tz_q;
    t_d         = t_q;
    rem_d       = rem_q;
    days_d      = days_q;
    hour_d      = hour_q;
    min_d       = min_q;
    year_d      = year_q;
    y4_d        = y4_q;
    y100_d      = y100_q;
    y400_d      = y400_q;
    month_d     = month_q;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_hour_d  = out_hour_q;
    out_min_d   = out_min_q;
    out_sec_d   = out_sec_q;

    if (cfg_we_i) begin
      tz_d = cfg_wdata_i;
    end

    if (cmd_i.load) begin
      t_d     = ntp_seconds_i - NtpUnixOffset;
      year_d  = EpochYear;
      y4_d    = EpochMod4;
      y100_d  = EpochMod100;
      y400_d  = EpochMod400;
      month_d = '0;
    end

    if (cmd_i.adjust) begin
      t_d = t_adj;
    end

    // day count first, then the second of the day from it
    if (cmd_i.day_step) begin
      if (!cmd_i.step_idx) begin
        days_d = day_prod[50:35];
      end else begin
        rem_d = t_q[16:0] - day_mul;
      end
    end

    if (cmd_i.hour_step) begin
      if (!cmd_i.step_idx) begin
        hour_d = hour_prod[25:21];
      end else begin
        rem_d = rem_q - hour_mul;
      end
    end

    if (cmd_i.min_step) begin
      if (!cmd_i.step_idx) begin
        min_d = min_prod[19:14];
      end else begin
        rem_d = rem_q - min_mul;
      end
    end

    if (cmd_i.year_step) begin
      days_d = days_q - 16'(ylen);
      year_d = year_q + 12'd1;
      y4_d   = y4_q + 2'd1;
      y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
      y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
    end

    if (cmd_i.month_step) begin
      days_d  = days_q - 16'(mlen);
      month_d = month_q + 4'd1;
    end

    if (cmd_i.out_load) begin
      out_year_d  = year_q;
      out_month_d = month_q + 4'd1;
      out_day_d   = days_q[DayW-1:0] + 5'd1;
      out_hour_d  = hour_q;
      out_min_d   = min_q;
      out_sec_d   = rem_q[SecondW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q <= TzReset;
    end else begin
      tz_q <= tz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    rem_q       <= rem_d;
    days_q      <= days_d;
    hour_q      <= hour_d;
    min_q       <= min_d;
    year_q      <= year_d;
    y4_q        <= y4_d;
    y100_q      <= y100_d;
    y400_q      <= y400_d;
    month_q     <= month_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_hour_q  <= out_hour_d;
    out_min_q   <= out_min_d;
    out_sec_q   <= out_sec_d;
  end

  assign result_o = {2'b00, out_sec_q, out_min_q, out_hour_q, out_day_q, out_month_q,
                     out_year_q};

endmodule

`default_nettype wire

>>> sv/ntpcal_ctrl.sv
`default_nettype none

module ntpcal_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  input  wire ntpcal_pkg::ntpcal_status_t status_i,
  output ntpcal_pkg::ntpcal_cmd_t      cmd_o
);
  import ntpcal_pkg::*;

  ntpcal_state_e state_q, state_d;
  logic          cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_ADJ;
        end
      end
      ST_ADJ: begin
        state_d = ST_DAY;
        cnt_d   = '0;
      end
      ST_DAY: begin
        if (cnt_q == DayLastStep) begin
          state_d = ST_HOUR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_HOUR: begin
        if (cnt_q == HourLastStep) begin
          state_d = ST_MIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MIN: begin
        if (cnt_q == MinuteLastStep) begin
          state_d = ST_YEAR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status_i.month_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.step_idx = cnt_q;
    s_axis_tready  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      ST_ADJ:   cmd_o.adjust    = 1'b1;
      ST_DAY:   cmd_o.day_step  = 1'b1;
      ST_HOUR:  cmd_o.hour_step = 1'b1;
      ST_MIN:   cmd_o.min_step  = 1'b1;
      ST_YEAR:  cmd_o.year_step  = !status_i.year_done;
      ST_MONTH: cmd_o.month_step = !status_i.month_done;
      ST_DONE:  cmd_o.out_load   = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten before transfer");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_ADJ))
    else $error("accepted item did not start conversion");

  a_day_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DAY && cnt_q == DayLastStep) |=> (state_q == ST_HOUR))
    else $error("day division did not finish after its last step");

  a_hour_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOUR && cnt_q == HourLastStep) |=> (state_q == ST_MIN))
    else $error("hour split did not finish after its last step");

  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH && !status_i.month_done) |=> (state_q == ST_MONTH))
    else $error("month walk left early");

endmodule

`default_nettype wire

>>> sv/ntp_seconds_to_calendar_top.sv
// conversion time: grows with Y + M, Y = whole years since 1970
//   (0..136), M = whole months into the final year (0..11); Y + M never exceeds 146
// items: converted one at a time, a new one only after the last has finished its year and
//   month walk; the next item is taken while a result still waits
// reset: asynchronous active low; clears control and sets timezone_hours to +8
`default_nettype none

module ntp_seconds_to_calendar_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration: timezone_hours, signed, whole hours
  input  wire logic                         cfg_we_i,
  input  wire logic [ntpcal_pkg::TzW-1:0]   cfg_wdata_i,
  // input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [ntpcal_pkg::NtpW-1:0]  s_axis_tdata,  // [31:0] ntp_seconds
  // output stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  output logic [ntpcal_pkg::OutW-1:0]       m_axis_tdata
);
  import ntpcal_pkg::*;

  ntpcal_cmd_t    cmd;
  ntpcal_status_t status;

  // sequencer: load, timezone add, day division, h/m/s split, year and month walk
  ntpcal_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // arithmetic, leap rule counters, config register and result register
  ntpcal_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ntp_seconds_i (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .result_o      (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_ntp_seconds_to_calendar_top.sv
module tb_ntp_seconds_to_calendar_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpcal_pkg::*;

  // result layout, lowest bits last: year at [11:0] up to the zero pad at [39:38]
  typedef struct packed {
    logic [1:0]         pad;
    logic [SecondW-1:0] secs;
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } calendar_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [TzW-1:0]   cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic [NtpW-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tready = 1'b0;
  wire logic        s_axis_tready;
  wire logic        m_axis_tvalid;
  wire logic [OutW-1:0] m_axis_tdata;

  // timezone the block holds right now, mirrored on every write
  logic signed [TzW-1:0] tz_setting = TzReset;
  calendar_t pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 12;

  ntp_seconds_to_calendar_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // m counts from 1
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && is_leap(y)) begin
      return 29;
    end
    return lens[m-1];
  endfunction

  // expected calendar fields for one timestamp under a given timezone
  function automatic calendar_t calendar_of(input logic [NtpW-1:0] ntp, input logic [TzW-1:0] tz);
    logic [31:0] tz_secs;
    logic [31:0] unix_secs;
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    calendar_t   cal;
    tz_secs   = {{(32-TzW){tz[TzW-1]}}, tz} * 32'd3600;
    unix_secs = ntp - NtpUnixOffset + tz_secs;
    days      = unix_secs / 32'd86400;
    sod       = unix_secs % 32'd86400;
    yr        = EpochYear;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < 12 && days >= days_in_month(yr, mon)) begin
      days -= days_in_month(yr, mon);
      mon++;
    end
    cal        = '0;
    cal.year   = YearW'(yr);
    cal.month  = MonthW'(mon);
    cal.day    = DayW'(days + 1);
    cal.hour   = HourW'(sod / 3600);
    cal.minute = MinuteW'((sod % 3600) / 60);
    cal.secs   = SecondW'(sod % 60);
    return cal;
  endfunction

  // ntp timestamp that shows as the given local time under the current timezone
  function automatic logic [NtpW-1:0] local_to_ntp(input int unsigned y, input int unsigned m,
                                                   input int unsigned d, input int unsigned hh,
                                                   input int unsigned mm, input int unsigned ss);
    int unsigned days = 0;
    logic [31:0] unix_secs;
    for (int unsigned yy = 1970; yy < y; yy++) begin
      days += is_leap(yy) ? 366 : 365;
    end
    for (int unsigned mo = 1; mo < m; mo++) begin
      days += days_in_month(y, mo);
    end
    days += d - 1;
    unix_secs = days * 86400 + hh * 3600 + mm * 60 + ss;
    return unix_secs + NtpUnixOffset - 32'(int'(tz_setting) * 3600);
  endfunction

  // mostly plain random, the rest clustered on year and month edges and pre-1970 values
  function automatic logic [NtpW-1:0] pick_timestamp();
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int          off;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      return $urandom();
    end
    if (kind < 80) begin
      y   = $urandom_range(1971, 2106);
      off = int'($urandom_range(0, 6)) - 3;
      return local_to_ntp(y, 1, 1, 0, 0, 0) + 32'(off);
    end
    if (kind < 95) begin
      y = $urandom_range(1970, 2105);
      m = $urandom_range(1, 12);
      return local_to_ntp(y, m, days_in_month(y, m), 23, 59, 58) + $urandom_range(0, 3);
    end
    return $urandom_range(0, NtpUnixOffset - 1);
  endfunction

  // one input transfer; tvalid stays high afterwards until the next call or a drain
  task automatic send_timestamp(input logic [NtpW-1:0] ts);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(calendar_of(ts, tz_setting));
  endtask

  task automatic wait_all_dates();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
  endtask

  // only called with the block idle
  task automatic set_timezone(input int hrs);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= TzW'(hrs);
    tz_setting   = TzW'(hrs);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: check each transfer against the oldest expectation, stall at random
  always @(posedge clk_i) begin
    calendar_t got;
    calendar_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_dates.size() == 0) begin
        $display("%0t: result %h with no timestamp outstanding", $time, got);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        compare_field("year", want.year, got.year);
        compare_field("month", want.month, got.month);
        compare_field("day", want.day, got.day);
        compare_field("hour", want.hour, got.hour);
        compare_field("minute", want.minute, got.minute);
        compare_field("second", want.secs, got.secs);
        compare_field("pad", want.pad, got.pad);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // reset timezone of +8 left unwritten; epoch edges, leap days and month ends
  task automatic test_leap_and_epoch_dates();
    send_timestamp(32'h0000_0000);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(NtpUnixOffset);
    send_timestamp(local_to_ntp(1970, 1, 1, 0, 0, 0));
    send_timestamp(local_to_ntp(1970, 1, 1, 0, 0, 0) - 1);
    send_timestamp(local_to_ntp(1972, 2, 29, 12, 34, 56));
    send_timestamp(local_to_ntp(2000, 2, 29, 23, 59, 59));
    send_timestamp(local_to_ntp(2000, 3, 1, 0, 0, 0));
    send_timestamp(local_to_ntp(2004, 1, 1, 0, 0, 0));
    send_timestamp(local_to_ntp(2004, 12, 31, 23, 59, 59));
    // 2100 is not a leap year
    send_timestamp(local_to_ntp(2100, 2, 28, 23, 59, 59));
    send_timestamp(local_to_ntp(2100, 3, 1, 0, 0, 0));
    send_timestamp(local_to_ntp(2023, 4, 30, 13, 7, 42));
    send_timestamp(local_to_ntp(2106, 2, 7, 6, 28, 15));
    wait_all_dates();
  endtask

  // register extremes, including values outside the nominal range,
  // with the offset carrying the count through both ends of the window
  task automatic test_timezone_extremes();
    int tz_list[4] = '{-16, -12, 14, 15};
    foreach (tz_list[i]) begin
      set_timezone(tz_list[i]);
      send_timestamp(NtpUnixOffset);
      send_timestamp(NtpUnixOffset - 1);
      send_timestamp($urandom());
      wait_all_dates();
    end
  endtask

  // random timestamps in several timezone phases, one phase without any idling
  task automatic test_random_dates();
    for (int phase = 0; phase < 5; phase++) begin
      set_timezone($urandom_range(0, 31));
      tx_idle_pct = (phase == 2) ? 0 : 12;
      rx_idle_pct = (phase == 2) ? 0 : 12;
      repeat (280) send_timestamp(pick_timestamp());
      wait_all_dates();
    end
    tx_idle_pct = 12;
    rx_idle_pct = 12;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_leap_and_epoch_dates();
    test_timezone_extremes();
    test_random_dates();
    // room for a stray result after the last expected one
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("tb_ntp_seconds_to_calendar_top: PASS");
    end else begin
      $display("tb_ntp_seconds_to_calendar_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_ntp_seconds_to_calendar_top: FAIL");
    $finish;
  end

endmodule
